// ----- hw/rtl/vcd_pkg.sv -----
`default_nettype none

package vcd_pkg;

	// Parse phases
	localparam logic [3:0] PH_MAJOR  = 4'd0;
	localparam logic [3:0] PH_MINOR  = 4'd1;
	localparam logic [3:0] PH_ACNT   = 4'd2;
	localparam logic [3:0] PH_A_BASE = 4'd3;
	localparam logic [3:0] PH_A_LAST = 4'd6;
	localparam logic [3:0] PH_SCNT   = 4'd7;
	localparam logic [3:0] PH_S_BASE = 4'd8;
	localparam logic [3:0] PH_S_LAST = 4'd11;
	localparam logic [3:0] PH_DONE   = 4'd12;
	localparam logic [3:0] PH_HALT   = 4'd13;

	// Offsets of the parts of one record
	localparam logic [1:0] OFF_NLEN = 2'd0;
	localparam logic [1:0] OFF_NAME = 2'd1;
	localparam logic [1:0] OFF_PLEN = 2'd2;
	localparam logic [1:0] OFF_PAY  = 2'd3;

	localparam logic [1:0] SEC_HEADER = 2'd0;
	localparam logic [1:0] SEC_ASSET  = 2'd1;
	localparam logic [1:0] SEC_SCRIPT = 2'd2;
	localparam logic [1:0] SEC_BEYOND = 2'd3;

	localparam logic [2:0] KIND_MAJOR    = 3'd0;
	localparam logic [2:0] KIND_MINOR    = 3'd1;
	localparam logic [2:0] KIND_COUNT    = 3'd2;
	localparam logic [2:0] KIND_NAME_LEN = 3'd3;
	localparam logic [2:0] KIND_IGNORED  = 3'd7;

	localparam logic [2:0] ST_BUSY        = 3'd0;
	localparam logic [2:0] ST_OK          = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_TRAILING    = 3'd3;
	localparam logic [2:0] ST_TRUNCATED   = 3'd4;
	localparam logic [2:0] ST_VARINT_LONG = 3'd5;

	localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

	typedef struct packed {
		logic [3:0]  phase;
		logic [7:0]  major;
		logic [31:0] accum;
		logic [2:0]  vcount;
		logic [31:0] recs_left;
		logic [31:0] bytes_left;
		logic [31:0] rec_idx;
		logic [2:0]  sticky;
	} vcd_state_t;

	localparam vcd_state_t STATE_RESET = '{
		phase: PH_MAJOR, major: 8'd0, accum: 32'd0, vcount: 3'd0,
		recs_left: 32'd0, bytes_left: 32'd0, rec_idx: 32'd0, sticky: ST_BUSY
	};

	typedef struct packed {
		logic [1:0]  section;
		logic [2:0]  kind;
		logic [7:0]  byte_val;
		logic        value_valid;
		logic [31:0] value;
		logic [31:0] recno;
		logic [2:0]  status;
	} vcd_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vcd_step.sv -----
`default_nettype none

module vcd_step (
	input  vcd_pkg::vcd_state_t  cur,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	input  wire logic [11:0]     max_ver,
	output vcd_pkg::vcd_state_t  nxt,
	output vcd_pkg::vcd_result_t res
);
	import vcd_pkg::*;

	logic [11:0] version;
	logic        in_a;
	logic [3:0]  base;
	logic [3:0]  diff;
	logic [1:0]  off;
	logic        is_cnt;
	logic [3:0]  after_sec;
	logic [31:0] rl_dec;
	logic [31:0] shifted;
	logic [31:0] new_acc;
	logic [2:0]  cnt_inc;

	assign version = {1'b0, cur.major, 3'b000} + {3'b000, cur.major, 1'b0}
		+ {4'b0000, data_byte};
	assign in_a      = (cur.phase <= PH_A_LAST);
	assign base      = in_a ? PH_A_BASE : PH_S_BASE;
	assign diff      = cur.phase - base;
	assign is_cnt    = (cur.phase == PH_ACNT) || (cur.phase == PH_SCNT);
	assign off       = is_cnt ? OFF_NLEN : diff[1:0];
	assign after_sec = in_a ? PH_SCNT : PH_DONE;
	assign rl_dec    = cur.recs_left - 32'd1;
	assign cnt_inc   = cur.vcount + 3'd1;
	assign new_acc   = cur.accum | shifted;

	// place the seven payload bits; bits beyond the word are dropped
	always_comb begin
		unique case (cur.vcount)
			3'd0: shifted = {25'd0, data_byte[6:0]};
			3'd1: shifted = {18'd0, data_byte[6:0], 7'd0};
			3'd2: shifted = {11'd0, data_byte[6:0], 14'd0};
			3'd3: shifted = {4'd0, data_byte[6:0], 21'd0};
			3'd4: shifted = {data_byte[3:0], 28'd0};
			default: shifted = 32'd0;
		endcase
	end

	always_comb begin
		nxt = cur;
		res.section     = SEC_BEYOND;
		res.kind        = KIND_IGNORED;
		res.byte_val    = data_byte;
		res.value_valid = 1'b0;
		res.value       = 32'd0;
		res.recno       = 32'd0;
		res.status      = ST_BUSY;

		priority if (cur.phase == PH_MAJOR) begin
			res.section     = SEC_HEADER;
			res.kind        = KIND_MAJOR;
			res.value_valid = 1'b1;
			res.value       = {24'd0, data_byte};
			nxt.major       = data_byte;
			nxt.phase       = PH_MINOR;
		end else if (cur.phase == PH_MINOR) begin
			res.section     = SEC_HEADER;
			res.kind        = KIND_MINOR;
			res.value_valid = 1'b1;
			res.value       = {24'd0, data_byte};
			if (version > max_ver) begin
				nxt.sticky = ST_BAD_VERSION;
				nxt.phase  = PH_HALT;
			end else begin
				nxt.phase  = PH_ACNT;
				nxt.accum  = 32'd0;
				nxt.vcount = 3'd0;
			end
		end else if (cur.phase >= PH_ACNT && cur.phase <= PH_S_LAST) begin
			res.section = in_a ? SEC_ASSET : SEC_SCRIPT;
			res.kind    = is_cnt ? KIND_COUNT : KIND_NAME_LEN + {1'b0, off};
			res.recno   = is_cnt ? 32'd0 : cur.rec_idx;
			if (!is_cnt && (off == OFF_NAME || off == OFF_PAY)) begin
				// raw bytes: count down the length
				if (cur.bytes_left <= 32'd1) begin
					nxt.bytes_left = 32'd0;
					if (off == OFF_NAME) begin
						nxt.phase = base + {2'b00, OFF_PLEN};
					end else begin
						nxt.recs_left = rl_dec;
						if (rl_dec == 32'd0) begin
							nxt.rec_idx = 32'd0;
							nxt.phase   = after_sec;
						end else begin
							nxt.rec_idx = cur.rec_idx + 32'd1;
							nxt.phase   = base + {2'b00, OFF_NLEN};
						end
					end
				end else begin
					nxt.bytes_left = cur.bytes_left - 32'd1;
				end
			end else if (data_byte[7]) begin
				nxt.accum  = new_acc;
				nxt.vcount = cnt_inc;
				if (cnt_inc >= VARINT_MAX_BYTES) begin
					nxt.sticky = ST_VARINT_LONG;
					nxt.phase  = PH_HALT;
				end
			end else begin
				res.value_valid = 1'b1;
				res.value       = new_acc;
				nxt.accum       = 32'd0;
				nxt.vcount      = 3'd0;
				if (is_cnt) begin
					nxt.recs_left = new_acc;
					nxt.rec_idx   = 32'd0;
					if (new_acc == 32'd0) begin
						nxt.phase = after_sec;
					end else begin
						nxt.phase = base + {2'b00, OFF_NLEN};
					end
				end else if (off == OFF_NLEN) begin
					nxt.bytes_left = new_acc;
					nxt.phase = (new_acc == 32'd0) ? base + {2'b00, OFF_PLEN}
						: base + {2'b00, OFF_NAME};
				end else begin
					nxt.bytes_left = new_acc;
					if (new_acc != 32'd0) begin
						nxt.phase = base + {2'b00, OFF_PAY};
					end else begin
						nxt.recs_left = rl_dec;
						if (rl_dec == 32'd0) begin
							nxt.rec_idx = 32'd0;
							nxt.phase   = after_sec;
						end else begin
							nxt.rec_idx = cur.rec_idx + 32'd1;
							nxt.phase   = base + {2'b00, OFF_NLEN};
						end
					end
				end
			end
		end else if (cur.phase == PH_DONE) begin
			if (cur.sticky == ST_BUSY) begin
				nxt.sticky = ST_TRAILING;
			end
		end else begin
			// halted or spare phase: drop the byte
			nxt = cur;
		end

		if (last_byte) begin
			if (nxt.sticky != ST_BUSY) begin
				res.status = nxt.sticky;
			end else begin
				res.status = (nxt.phase == PH_DONE) ? ST_OK : ST_TRUNCATED;
			end
			nxt = STATE_RESET;
		end else begin
			res.status = nxt.sticky;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/varint_container_deframer.sv -----
`default_nettype none

// Channel   Direction  Handshake             Word
// in        sink       in_valid / in_ready   data_byte, last_byte
// out       source     out_valid / out_ready section .. status
// cfg       sink       cfg_wr_en             cfg_wr_data (max_supported_version)
//
// One word a cycle while the output is not stalled: a single pass of logic parses
// each byte from the parser state into the output register, so out_valid rises in
// the cycle after accept. in_ready is high while the output register is empty or
// being taken, so a stalled output word holds the input in that same cycle.
// arst_n clears the parser state and out_valid and sets the version limit to
// 255; the word marked last restarts the parser.

module varint_container_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       section,
	output logic [2:0]       field_kind,
	output logic [7:0]       byte_out,
	output logic             value_valid,
	output logic [31:0]      field_value,
	output logic [31:0]      record_number,
	output logic [2:0]       status,
	input  wire logic        cfg_wr_en,
	input  wire logic [11:0] cfg_wr_data
);
	import vcd_pkg::*;

	vcd_state_t  state_q;
	vcd_state_t  state_nxt;
	vcd_result_t res;
	vcd_result_t res_q;
	logic        out_valid_q;
	logic [11:0] max_ver_q;
	logic        accept;

	// take a new word whenever the output slot frees up this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	vcd_step u_step (
		.cur       (state_q),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.max_ver   (max_ver_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ver_q <= 12'd255;
		end else if (cfg_wr_en) begin
			max_ver_q <= cfg_wr_data;
		end
	end

	// advance the parser only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// hold the result while the sink stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign section       = res_q.section;
	assign field_kind    = res_q.kind;
	assign byte_out      = res_q.byte_val;
	assign value_valid   = res_q.value_valid;
	assign field_value   = res_q.value;
	assign record_number = res_q.recno;
	assign status        = res_q.status;

endmodule

`default_nettype wire

// ----- tb/varint_container_deframer_tb.sv -----
`timescale 1ns / 100ps

module varint_container_deframer_tb;

	import vcd_pkg::*;

	// Predicts every output word of the deframer and keeps the words that are
	// still owed by the block, oldest first.
	class container_scoreboard;
		logic [11:0] version_limit;
		logic [3:0]  phase;
		logic [7:0]  major;
		logic [31:0] accum;
		logic [2:0]  vbytes;
		logic [31:0] recs_left;
		logic [31:0] bytes_left;
		logic [31:0] rec_idx;
		logic [2:0]  sticky;

		vcd_result_t owed_words[$];
		int          mismatches;
		int          words_checked;
		int          words_parsed;
		int          files_seen;
		int          ends_with[8];

		function new();
			version_limit = 12'd255;
			restart();
			mismatches = 0;
			words_checked = 0;
			words_parsed = 0;
			files_seen = 0;
			foreach (ends_with[i])
				ends_with[i] = 0;
		endfunction

		function void restart();
			phase = PH_MAJOR;
			major = '0;
			accum = '0;
			vbytes = '0;
			recs_left = '0;
			bytes_left = '0;
			rec_idx = '0;
			sticky = ST_BUSY;
		endfunction

		function void set_limit(logic [11:0] v);
			version_limit = v;
		endfunction

		// advance past one record; the last asset record hands over to the script count, the last script record to done
		function void close_record(logic [3:0] base);
			recs_left = recs_left - 1;
			rec_idx = rec_idx + 1;
			if (recs_left == 0) begin
				rec_idx = '0;
				phase = (base == PH_A_BASE) ? PH_SCNT : PH_DONE;
			end else begin
				phase = base + 4'(OFF_NLEN);
			end
		endfunction

		function void note_byte(logic [7:0] b, logic is_last);
			vcd_result_t r;
			logic [3:0]  p;
			logic [3:0]  base;
			logic [1:0]  off;
			logic        is_cnt;
			logic [31:0] v;
			logic [63:0] wide;
			int          sh;
			r = '{section: SEC_BEYOND, kind: KIND_IGNORED, byte_val: b, value_valid: 1'b0,
				value: 32'd0, recno: 32'd0, status: ST_BUSY};
			p = phase;
			if (p == PH_MAJOR) begin
				r.section = SEC_HEADER;
				r.kind = KIND_MAJOR;
				r.value_valid = 1'b1;
				r.value = 32'(b);
				major = b;
				phase = PH_MINOR;
			end else if (p == PH_MINOR) begin
				r.section = SEC_HEADER;
				r.kind = KIND_MINOR;
				r.value_valid = 1'b1;
				r.value = 32'(b);
				if (32'(major) * 10 + 32'(b) > 32'(version_limit)) begin
					sticky = ST_BAD_VERSION;
					phase = PH_HALT;
				end else begin
					phase = PH_ACNT;
					accum = '0;
					vbytes = '0;
				end
			end else if (p >= PH_ACNT && p <= PH_S_LAST) begin
				base = (p <= PH_A_LAST) ? PH_A_BASE : PH_S_BASE;
				is_cnt = (p == PH_ACNT || p == PH_SCNT);
				off = is_cnt ? OFF_NLEN : 2'(p - base);
				r.section = (base == PH_A_BASE) ? SEC_ASSET : SEC_SCRIPT;
				// record parts follow the name length code in the order they arrive
				r.kind = is_cnt ? KIND_COUNT : KIND_NAME_LEN + 3'(off);
				r.recno = is_cnt ? 32'd0 : rec_idx;
				if (!is_cnt && (off == OFF_NAME || off == OFF_PAY)) begin
					if (bytes_left <= 1) begin
						bytes_left = '0;
						if (off == OFF_NAME)
							phase = base + 4'(OFF_PLEN);
						else
							close_record(base);
					end else begin
						bytes_left = bytes_left - 1;
					end
				end else begin
					sh = 7 * int'(vbytes);
					if (sh < 32) begin
						wide = 64'(b[6:0]) << sh;
						accum = accum | wide[31:0];
					end
					vbytes = vbytes + 3'd1;
					if (b[7]) begin
						if (vbytes >= VARINT_MAX_BYTES) begin
							sticky = ST_VARINT_LONG;
							phase = PH_HALT;
						end
					end else begin
						v = accum;
						r.value_valid = 1'b1;
						r.value = v;
						accum = '0;
						vbytes = '0;
						if (is_cnt) begin
							recs_left = v;
							rec_idx = '0;
							if (v == 0)
								phase = (p == PH_ACNT) ? PH_SCNT : PH_DONE;
							else
								phase = base + 4'(OFF_NLEN);
						end else if (off == OFF_NLEN) begin
							bytes_left = v;
							phase = (v == 0) ? base + 4'(OFF_PLEN) : base + 4'(OFF_NAME);
						end else begin
							bytes_left = v;
							if (v == 0)
								close_record(base);
							else
								phase = base + 4'(OFF_PAY);
						end
					end
				end
			end else if (p == PH_DONE) begin
				if (sticky == ST_BUSY)
					sticky = ST_TRAILING;
			end

			if (is_last) begin
				if (sticky != ST_BUSY)
					r.status = sticky;
				else
					r.status = (phase == PH_DONE) ? ST_OK : ST_TRUNCATED;
				ends_with[r.status]++;
				files_seen++;
				restart();
			end else begin
				r.status = sticky;
			end

			if (r.kind != KIND_IGNORED)
				words_parsed++;
			owed_words = {owed_words, r};
		endfunction

		function void check_word(vcd_result_t got);
			vcd_result_t want;
			words_checked++;
			if (owed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word byte %02h status %0d", $realtime,
						got.byte_val, got.status);
				return;
			end
			want = owed_words.pop_front();
			if (got.section !== want.section || got.kind !== want.kind ||
				got.byte_val !== want.byte_val || got.value_valid !== want.value_valid ||
				got.value !== want.value || got.recno !== want.recno ||
				got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: want sec %0d kind %0d byte %02h vv %0b val %0h rec %0d st %0d",
						$realtime, want.section, want.kind, want.byte_val, want.value_valid,
						want.value, want.recno, want.status);
					$display("%0t:  got sec %0d kind %0d byte %02h vv %0b val %0h rec %0d st %0d",
						$realtime, got.section, got.kind, got.byte_val, got.value_valid,
						got.value, got.recno, got.status);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  section;
	logic [2:0]  field_kind;
	logic [7:0]  byte_out;
	logic        value_valid;
	logic [31:0] field_value;
	logic [31:0] record_number;
	logic [2:0]  status;
	logic        cfg_wr_en = 1'b0;
	logic [11:0] cfg_wr_data = 12'd0;

	vcd_result_t         seen_word;
	container_scoreboard sb;

	// percentage of cycles on which each side holds off
	int sender_idle_pct = 0;
	int sink_idle_pct = 0;
	int cur_limit = 255;

	// bytes of the file under construction, and where in it the sender drains
	logic [7:0] file_bytes[$];
	int         hold_at;

	varint_container_deframer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.section       (section),
		.field_kind    (field_kind),
		.byte_out      (byte_out),
		.value_valid   (value_valid),
		.field_value   (field_value),
		.record_number (record_number),
		.status        (status),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #2 clk = ~clk;

	assign seen_word = {section, field_kind, byte_out, value_valid, field_value,
		record_number, status};

	// Receiver: check the word taken at this edge, then choose whether to stall
	// for the next one. Signals read here still hold their pre-edge values.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(seen_word);
		out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Offer one word; idle gaps come before it, never while it is pending.
	task automatic push_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(b, is_last);
	endtask

	// Hold the sender off until the block owes nothing more.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed_words.size() != 0)
			@(posedge clk);
	endtask

	// Only called with the block drained, so the new limit never lands mid-file.
	task automatic write_limit(input int v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= 12'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_limit(12'(v));
		cur_limit = v;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++) begin
			if (i == hold_at)
				drain();
			push_byte(file_bytes[i], i == file_bytes.size() - 1);
		end
	endtask

	// LEB128 with optional redundant continuation bytes, never past five bytes.
	// A fifth byte carries junk in the bits above bit 31, which must be dropped.
	task automatic put_varint(input logic [31:0] v, input int pad);
		int         need;
		int         total;
		logic [7:0] b;
		need = 1;
		while (need < 5 && (v >> (7 * need)) != 0)
			need++;
		total = (need + pad > 5) ? 5 : need + pad;
		for (int i = 0; i < total; i++) begin
			b = 8'((v >> (7 * i)) & 32'h7F);
			if (i != total - 1)
				b[7] = 1'b1;
			else if (i == 4)
				b[6:4] = 3'($urandom_range(0, 7));
			file_bytes = {file_bytes, b};
		end
	endtask

	function automatic int pick_pad();
		return ($urandom_range(0, 9) < 2) ? $urandom_range(1, 3) : 0;
	endfunction

	task automatic put_noise(input int n);
		repeat (n)
			file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
	endtask

	task automatic put_version(input bit fits);
		int hi_major;
		int maj;
		int rest;
		if (fits) begin
			hi_major = (cur_limit / 10 > 255) ? 255 : cur_limit / 10;
			maj = $urandom_range(0, hi_major);
			rest = cur_limit - maj * 10;
			file_bytes = {file_bytes, 8'(maj)};
			file_bytes = {file_bytes, 8'($urandom_range(0, (rest > 255) ? 255 : rest))};
		end else begin
			put_noise(2);
		end
	endtask

	task automatic put_record();
		int nlen;
		int plen;
		nlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
		plen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
		put_varint(nlen, pick_pad());
		put_noise(nlen);
		put_varint(plen, pick_pad());
		put_noise(plen);
	endtask

	task automatic put_section();
		int n;
		n = $urandom_range(0, 3);
		put_varint(n, pick_pad());
		repeat (n)
			put_record();
	endtask

	task automatic put_long_varint();
		repeat (5)
			file_bytes = {file_bytes, 8'($urandom_range(0, 255)) | 8'h80};
	endtask

	// Mostly well-formed files with random content; the rest are cut short,
	// padded at the end, over-long, of an unsupported version or plain noise.
	task automatic build_file();
		int pick;
		int keep;
		file_bytes.delete();
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			put_version(1'b1);
			put_section();
			put_section();
			if (pick >= 72) begin
				keep = $urandom_range(1, file_bytes.size());
				while (file_bytes.size() > keep)
					void'(file_bytes.pop_back());
			end else if (pick >= 65) begin
				put_noise($urandom_range(1, 3));
			end
		end else if (pick < 86) begin
			put_version(1'b1);
			case ($urandom_range(0, 2))
				0: put_long_varint();
				1: begin
					put_varint(32'd1, 0);
					put_long_varint();
				end
				default: begin
					put_varint(32'd0, 0);
					put_long_varint();
				end
			endcase
			put_noise($urandom_range(0, 3));
		end else if (pick < 91) begin
			put_version(1'b0);
			put_noise($urandom_range(0, 4));
		end else if (pick < 95) begin
			put_noise($urandom_range(1, 8));
		end else begin
			// count far beyond what follows, so record numbers climb and the file truncates
			put_version(1'b1);
			put_varint(32'($urandom()) | 32'h100, $urandom_range(0, 4));
			repeat ($urandom_range(1, 3))
				put_record();
		end
		hold_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, file_bytes.size() - 1) : -1;
	endtask

	initial begin
		int limits[6];
		int goal;

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed files under the reset limit of 255, with light idling.
		sender_idle_pct = 20;
		sink_idle_pct = 20;
		hold_at = -1;
		write_limit(255);
		// two assets, one with an empty payload and one with an empty name, no scripts
		file_bytes = '{8'h01, 8'h02, 8'h02, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01, 8'h42, 8'h00};
		send_file();
		// version 255.255 is above the limit; the rest is ignored
		file_bytes = '{8'hFF, 8'hFF, 8'h00};
		send_file();
		// asset count runs on into a sixth byte
		file_bytes = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12};
		send_file();
		// empty container followed by one stray byte
		file_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h7F};
		send_file();
		// file ends on its first byte
		file_bytes = '{8'h00};
		send_file();

		// Random files: slow receiver, then slow sender, then flat out.
		limits = '{2805, 0, 2047, 0, 255, 0};
		limits[3] = $urandom_range(0, 2805);
		limits[5] = $urandom_range(0, 400);
		for (int seg = 0; seg < 6; seg++) begin
			sender_idle_pct = (seg < 2) ? 37 : (seg < 4) ? 87 : 0;
			sink_idle_pct = (seg < 2) ? 87 : (seg < 4) ? 37 : 0;
			drain();
			write_limit(limits[seg]);
			goal = sb.words_parsed + 84;
			while (sb.words_parsed < goal) begin
				build_file();
				send_file();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.owed_words.size() != 0) begin
			$display("%0d words never came out", sb.owed_words.size());
			sb.mismatches += sb.owed_words.size();
		end

		$display("Parsed %0d files in %0d words: %0d ok, %0d bad version, %0d trailing,",
			sb.files_seen, sb.words_checked, sb.ends_with[ST_OK], sb.ends_with[ST_BAD_VERSION],
			sb.ends_with[ST_TRAILING]);
		$display("%0d truncated, %0d over-long varint; %0d mismatches",
			sb.ends_with[ST_TRUNCATED], sb.ends_with[ST_VARINT_LONG], sb.mismatches);
		if (sb.mismatches == 0)
			$display("[varint_container_deframer] OK");
		else
			$display("[varint_container_deframer] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("Timed out waiting on the deframer");
		$display("[varint_container_deframer] ERROR");
		$finish;
	end

endmodule
